// ----- rtl/sorted_priority_queue_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Sorted priority queue unit: assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Request/response types, op and status codes, cell control struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_TAKE_MAX = 2'd1;
  localparam logic [1:0] OP_TAKE_MIN = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       entry_count;
  } rsp_t;

  // broadcast to every cell each cycle
  typedef struct packed {
    logic                     insert_en;
    logic                     shift_en;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array: compares against the insert value and
// takes the insert value or data from its left or right neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  wire logic                             clk,
  input  wire spq_pkg::cell_ctrl_t              ctrl,
  input  wire logic                             occupied,
  input  wire logic                             left_ge,
  input  wire logic signed [spq_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [spq_pkg::DATA_W-1:0] right_data,
  output logic                                  ge,
  output logic signed [spq_pkg::DATA_W-1:0]     data
);

  logic signed [spq_pkg::DATA_W-1:0] data_r;
  logic signed [spq_pkg::DATA_W-1:0] data_nxt;

  // this slot stays ahead of the new value
  assign ge   = occupied && (data_r >= ctrl.value);
  assign data = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.insert_en) begin
      if (ge) begin
        data_nxt = data_r;
      end else if (left_ge) begin
        data_nxt = ctrl.value;
      end else begin
        data_nxt = left_data;
      end
    end else if (ctrl.shift_en) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/spq_skid.sv -----
// ----------------------------------------------------------------------------
// spq_skid
// Two-entry response buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_skid (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire spq_pkg::rsp_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output spq_pkg::rsp_t      pop_data
);

  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  spq_pkg::rsp_t out_data_r, out_data_nxt;
  spq_pkg::rsp_t skid_data_r, skid_data_nxt;
  logic          pop;
  logic          push;

  assign push_ready = !skid_valid_r;
  assign pop_valid  = out_valid_r;
  assign pop_data   = out_data_r;
  assign pop        = out_valid_r && pop_ready;
  assign push       = push_valid && push_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Usage: requests arrive on in_valid/in_ready/in_data (op, value), one
// response per request leaves on out_valid/out_ready/out_data.
// Ops: insert, remove largest, remove smallest. Removing from an empty queue
// gives -1 with status empty; inserting into a full queue is refused with
// status full. entry_count is the occupancy after the op (low 5 bits).
// Output: the response is registered, in the skid register if the output is held.
// Throughput: one request per cycle while in_ready is high; every cell of the
// sorted row updates in the accept cycle, so the next request sees the new order.
// Stall: a two-entry response buffer lets one more request in while a
// response waits; in_ready drops once both entries hold responses.
// Reset (rst_n, synchronous, active low): occupancy goes to zero and the
// response buffer empties; stored values are left as they are and are never
// read before being written again.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire spq_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output spq_pkg::rsp_t      out_data
);

  `include "sorted_priority_queue_unit_defines.svh"

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Occupancy counter
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic accept;
  logic is_insert, is_take_max, is_take_min;
  logic full, empty;
  logic insert_en, remove_en;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::rsp_t       rsp;
  logic                rsp_ready;

  // Per-cell wiring of the row; index 0 holds the largest entry
  logic                              occ   [CAPACITY];
  logic                              ge    [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] data  [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] tail_part [CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] tail_value;
  logic [CNT_W+spq_pkg::COUNT_W-1:0] cnt_ext;

  assign in_ready    = rsp_ready;
  assign accept      = in_valid && in_ready;
  assign is_insert   = in_data.op == spq_pkg::OP_INSERT;
  assign is_take_max = in_data.op == spq_pkg::OP_TAKE_MAX;
  assign is_take_min = in_data.op == spq_pkg::OP_TAKE_MIN;
  assign full        = cnt_r >= CNT_W'(CAPACITY);
  assign empty       = cnt_r == '0;
  assign insert_en   = accept && is_insert && !full;
  assign remove_en   = accept && (is_take_max || is_take_min) && !empty;

  assign ctrl.insert_en = insert_en;
  assign ctrl.shift_en  = remove_en && is_take_max;
  assign ctrl.value     = in_data.value;

  // Row of cells: insert opens a gap by shifting right, remove-largest
  // shifts the whole row left.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                              l_ge;
    logic signed [spq_pkg::DATA_W-1:0] l_data;
    logic signed [spq_pkg::DATA_W-1:0] r_data;

    assign occ[i] = cnt_r > CNT_W'(i);

    if (i == 0) begin : g_first
      assign l_ge   = 1'b1;
      assign l_data = in_data.value;
    end else begin : g_mid
      assign l_ge   = ge[i-1];
      assign l_data = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_data = data[i];
    end else begin : g_inner
      assign r_data = data[i+1];
    end

    // smallest entry sits in the last occupied cell
    assign tail_part[i] = (cnt_r == CNT_W'(i + 1)) ? data[i] : '0;

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ[i]),
      .left_ge   (l_ge),
      .left_data (l_data),
      .right_data(r_data),
      .ge        (ge[i]),
      .data      (data[i])
    );
  end

  always_comb begin
    tail_value = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      tail_value = tail_value | tail_part[k];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (insert_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (remove_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Response built from the pre-update row and the post-update count
  assign cnt_ext = {{spq_pkg::COUNT_W{1'b0}}, cnt_nxt};

  always_comb begin
    rsp.result_value = '0;
    rsp.status       = spq_pkg::ST_OK;
    rsp.entry_count  = cnt_ext[spq_pkg::COUNT_W-1:0];
    case (in_data.op)
      spq_pkg::OP_INSERT: begin
        if (full) begin
          rsp.status = spq_pkg::ST_FULL;
        end
      end
      spq_pkg::OP_TAKE_MAX: begin
        if (empty) begin
          rsp.result_value = spq_pkg::EMPTY_VALUE;
          rsp.status       = spq_pkg::ST_EMPTY;
        end else begin
          rsp.result_value = data[0];
        end
      end
      spq_pkg::OP_TAKE_MIN: begin
        if (empty) begin
          rsp.result_value = spq_pkg::EMPTY_VALUE;
          rsp.status       = spq_pkg::ST_EMPTY;
        end else begin
          rsp.result_value = tail_value;
        end
      end
      default: begin
        rsp.result_value = '0;
      end
    endcase
  end

  spq_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(in_valid),
    .push_ready(rsp_ready),
    .push_data (rsp),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (out_data)
  );

  // Checks
  `SPQ_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY), "occupancy above capacity")
  `SPQ_ASSERT_NEXT(a_cnt_inc, insert_en, cnt_r == $past(cnt_r) + CNT_W'(1), "insert miscounted")
  `SPQ_ASSERT_NEXT(a_cnt_dec, remove_en, cnt_r == $past(cnt_r) - CNT_W'(1), "remove miscounted")
  `SPQ_ASSERT_IMPL(a_ready_idle, !out_valid, in_ready, "not ready with empty response buffer")

endmodule

`default_nettype wire
